@@ rtl/core/assert_macros.svh @@
// Assertion macros for the supervisor RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every clock edge outside reset
`define CHK_IMPL(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("check failed");
// implication whose consequent is checked in the cycle after its antecedent
`define CHK_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("check failed");
`endif

@@ rtl/core/prsd_pkg.sv @@
// Types and constants of the power rail supervisor display
package prsd_pkg;
	typedef struct packed {
		logic [15:0] volt_sample;
		logic [15:0] current_sample;
		logic [15:0] temp_sample;
		logic        ext_fault;
	} in_t;

	typedef struct packed {
		logic [7:0] digit_0;
		logic [7:0] digit_1;
		logic [7:0] digit_2;
		logic [7:0] digit_3;
		logic       load_on;
		logic [2:0] fault_code;
	} out_t;

	localparam logic [2:0] REG_TEMP_LIMIT = 3'd0;
	localparam logic [2:0] REG_CURRENT_LIMIT = 3'd1;
	localparam logic [2:0] REG_VOLT_HIGH = 3'd2;
	localparam logic [2:0] REG_VOLT_LOW = 3'd3;
	localparam logic [2:0] REG_FAULT_HOLD = 3'd4;
	localparam logic [2:0] REG_EXT_HOLD = 3'd5;
	localparam logic [2:0] REG_COOLDOWN = 3'd6;
	localparam logic [2:0] REG_STARTUP = 3'd7;

	localparam logic [2:0] FC_NONE = 3'd0;
	localparam logic [2:0] FC_EXT = 3'd1;
	localparam logic [2:0] FC_VHIGH = 3'd2;
	localparam logic [2:0] FC_VLOW = 3'd3;
	localparam logic [2:0] FC_IHIGH = 3'd4;
	localparam logic [2:0] FC_TEMP = 3'd5;

	localparam logic [7:0] SYM_C = 8'd12;
	localparam logic [7:0] SYM_E = 8'd14;
	localparam logic [7:0] SYM_F = 8'd15;
	localparam logic [7:0] SYM_LC = 8'd17;
	localparam logic [7:0] SYM_R = 8'd19;
	localparam logic [7:0] SYM_BLANK = 8'd21;
	localparam logic [7:0] SYM_T = 8'd23;
	localparam logic [7:0] SYM_DASH = 8'd26;
	localparam logic [7:0] SYM_A = 8'hA;
	localparam logic [7:0] DOT = 8'h80;

	localparam logic [15:0] K_VOLT = 16'd2618;
	localparam logic [15:0] K_AMP = 16'd2940;
	localparam logic [15:0] K_TEMP = 16'd3330;
	localparam logic [31:0] T_OFFSET = 32'd600 << 16;
	localparam logic [13:0] SAT_MAX = 14'd9999;

	// datapath commands
	typedef enum logic [2:0] {
		DP_NONE,
		DP_LOAD,
		DP_MUL_V,
		DP_MUL_I,
		DP_MUL_T,
		DP_FAHR,
		DP_BCD
	} dp_op_t;

	typedef struct packed {
		dp_op_t     op;
		logic [1:0] bcd_sel;
	} dp_cmd_t;

	typedef struct packed {
		logic bcd_done;
	} dp_stat_t;

	function automatic logic [7:0] msg_digit(input logic [2:0] code, input logic [1:0] pos);
		logic [31:0] w;
		case (code)
			FC_EXT: w = {8'd11, 8'd10, 8'd13, 8'd21};
			FC_VHIGH: w = {8'd24, 8'd25, 8'd11, 8'd23};
			FC_VLOW: w = {8'd22, 8'd20, 8'd11, 8'd23};
			FC_IHIGH: w = {8'd24, 8'd25, 8'd12, 8'd19};
			FC_TEMP: w = {8'd24, 8'd20, 8'd23, 8'd21};
			FC_NONE: w = {8'd9, 8'd20, 8'd20, 8'd13};
			default: w = {8'd11, 8'd10, 8'd13, 8'd21};
		endcase
		return w[(3 - pos) * 8 +: 8];
	endfunction
endpackage

@@ rtl/core/prsd_datapath.sv @@
// Filters, scalers and decimal converter of the supervisor
module prsd_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  prsd_pkg::in_t       req,
	input  prsd_pkg::dp_cmd_t   cmd,
	output prsd_pkg::dp_stat_t  stat,
	output logic [13:0]         volts,
	output logic [13:0]         amps,
	output logic signed [12:0]  deg,
	output logic [9:0]          fahr,
	output logic [3:0]          dig_q [4]
);
	logic [15:0] vf_q, if_q, tf_q;
	logic [31:0] prod;
	logic [15:0] mul_a, mul_b;
	logic [13:0] bcd_bin_q;
	logic [15:0] bcd_q;
	logic [15:0] bcd_adj;
	logic [3:0]  bcd_cnt_q;
	logic signed [32:0] dt;
	logic [9:0]  dclamp;

	function automatic logic [15:0] lp(input logic [15:0] old, input logic [15:0] x);
		logic [15:0] d;
		logic [15:0] q;
		d = (x >= old) ? x - old : old - x;
		q = 16'((32'(d) * 32'd43691) >> 17);
		return (x >= old) ? old + q : old - q;
	endfunction

	always_comb begin
		dclamp = deg[12] ? 10'd0 : (deg > 13'sd999 ? 10'd999 : deg[9:0]);
		case (cmd.op)
			prsd_pkg::DP_MUL_V: begin mul_a = vf_q; mul_b = prsd_pkg::K_VOLT; end
			prsd_pkg::DP_MUL_I: begin mul_a = if_q; mul_b = prsd_pkg::K_AMP; end
			prsd_pkg::DP_MUL_T: begin mul_a = tf_q; mul_b = prsd_pkg::K_TEMP; end
			default: begin mul_a = 16'(dclamp); mul_b = 16'd46; end
		endcase
		prod = mul_a * mul_b;
		dt = $signed({1'b0, prod}) - $signed({1'b0, prsd_pkg::T_OFFSET});
		for (int n = 0; n < 4; n++)
			bcd_adj[n * 4 +: 4] = (bcd_q[n * 4 +: 4] >= 4'd5) ? bcd_q[n * 4 +: 4] + 4'd3
				: bcd_q[n * 4 +: 4];
	end

	assign stat.bcd_done = (bcd_cnt_q == 4'd15);
	assign dig_q[0] = bcd_q[15:12];
	assign dig_q[1] = bcd_q[11:8];
	assign dig_q[2] = bcd_q[7:4];
	assign dig_q[3] = bcd_q[3:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vf_q <= '0;
			if_q <= '0;
			tf_q <= '0;
			volts <= '0;
			amps <= '0;
			deg <= '0;
			fahr <= '0;
			bcd_bin_q <= '0;
			bcd_q <= '0;
			bcd_cnt_q <= '0;
		end else begin
			case (cmd.op)
				prsd_pkg::DP_LOAD: begin
					vf_q <= lp(vf_q, req.volt_sample);
					if_q <= lp(if_q, req.current_sample);
					tf_q <= lp(tf_q, req.temp_sample);
				end
				prsd_pkg::DP_MUL_V:
					volts <= (prod[31:16] > 16'(prsd_pkg::SAT_MAX)) ? prsd_pkg::SAT_MAX
						: prod[29:16];
				prsd_pkg::DP_MUL_I:
					amps <= (prod[31:16] > 16'(prsd_pkg::SAT_MAX)) ? prsd_pkg::SAT_MAX
						: prod[29:16];
				prsd_pkg::DP_MUL_T:
					deg <= 13'(dt >>> 16);
				prsd_pkg::DP_FAHR:
					fahr <= 10'((prod + 32'd8192) >> 8);
				prsd_pkg::DP_BCD: begin
					if (bcd_cnt_q == 4'd0) begin
						case (cmd.bcd_sel)
							2'd0: bcd_bin_q <= volts;
							2'd1: bcd_bin_q <= amps;
							2'd2: bcd_bin_q <= 14'(dclamp);
							default: bcd_bin_q <= 14'(fahr);
						endcase
						bcd_q <= '0;
						bcd_cnt_q <= 4'd1;
					end else if (bcd_cnt_q == 4'd15) begin
						bcd_cnt_q <= 4'd0;
					end else begin
						{bcd_q, bcd_bin_q} <= {bcd_adj[14:0], bcd_bin_q, 1'b0};
						bcd_cnt_q <= bcd_cnt_q + 4'd1;
					end
				end
				default: ;
			endcase
		end
	end
endmodule

@@ rtl/core/prsd_ctrl.sv @@
// Sequencer and supervision state of the supervisor
`include "assert_macros.svh"
module prsd_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               ext_fault,
	output logic               out_valid,
	input  logic               out_ready,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_idx,
	input  logic [13:0]        cfg_data,
	output prsd_pkg::dp_cmd_t  cmd,
	input  prsd_pkg::dp_stat_t stat,
	input  logic [13:0]        volts,
	input  logic [13:0]        amps,
	input  logic signed [12:0] deg,
	input  logic [3:0]         dig [4],
	output logic [7:0]         shown_q [4],
	output logic               load_q,
	output logic [2:0]         code_q
);
	typedef enum logic [3:0] {
		S_IDLE, S_MV, S_MI, S_MT, S_FH, S_CHK, S_BCD, S_DISP, S_OUT
	} state_t;
	state_t state_q;

	logic [13:0] temp_lim_q, cur_lim_q, vhi_q, vlo_q;
	logic [7:0]  fhold_q, ehold_q, cool_ticks_q;
	logic [4:0]  grace_q;
	logic [7:0]  cool_q, hold_q;
	logic [2:0]  mode_q, dwell_q;
	logic        showerr_q, ext_q;

	logic [7:0] h;
	logic [2:0] c;
	logic       ld, cut;
	logic [7:0] cl;
	logic [3:0] d3 [4];

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign d3 = dig;

	always_comb begin
		h = hold_q;
		c = code_q;
		ld = load_q;
		cl = cool_q;
		cut = 1'b0;
		if (cool_q != 8'd0) begin
			cl = cool_q - 8'd1;
			if (cl == 8'd0)
				ld = 1'b1;
		end
		if (ext_q) begin
			if (h < ehold_q) h = ehold_q;
			c = prsd_pkg::FC_EXT;
			cut = 1'b1;
		end
		if (deg > $signed({1'b0, temp_lim_q[11:0]}) && temp_lim_q[13:12] == 2'd0
			|| 1'b0) begin
			if (h < fhold_q) h = fhold_q;
			c = prsd_pkg::FC_TEMP;
		end
		if (amps > cur_lim_q) begin
			if (h < fhold_q) h = fhold_q;
			c = prsd_pkg::FC_IHIGH;
			cut = 1'b1;
		end
		if (volts > vhi_q) begin
			if (h < fhold_q) h = fhold_q;
			c = prsd_pkg::FC_VHIGH;
			cut = 1'b1;
		end
		if (volts < vlo_q) begin
			if (h < fhold_q) h = fhold_q;
			c = prsd_pkg::FC_VLOW;
			cut = 1'b1;
		end
		if (cut) begin
			ld = 1'b0;
			cl = cool_ticks_q;
		end
	end

	always_comb begin
		cmd.op = prsd_pkg::DP_NONE;
		cmd.bcd_sel = 2'd0;
		case (state_q)
			S_IDLE: if (in_valid) cmd.op = prsd_pkg::DP_LOAD;
			S_MV: cmd.op = prsd_pkg::DP_MUL_V;
			S_MI: cmd.op = prsd_pkg::DP_MUL_I;
			S_MT: cmd.op = prsd_pkg::DP_MUL_T;
			S_FH: cmd.op = prsd_pkg::DP_FAHR;
			S_BCD: begin
				cmd.op = prsd_pkg::DP_BCD;
				case (mode_q)
					3'd1: cmd.bcd_sel = 2'd0;
					3'd5: cmd.bcd_sel = 2'd2;
					3'd6: cmd.bcd_sel = 2'd3;
					default: cmd.bcd_sel = 2'd1;
				endcase
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			temp_lim_q <= 14'd450;
			cur_lim_q <= 14'd1500;
			vhi_q <= 14'd1600;
			vlo_q <= 14'd1000;
			fhold_q <= 8'd120;
			ehold_q <= 8'd40;
			cool_ticks_q <= 8'd60;
			grace_q <= 5'd20;
			cool_q <= 8'd5;
			load_q <= 1'b0;
			hold_q <= '0;
			code_q <= prsd_pkg::FC_NONE;
			mode_q <= '0;
			dwell_q <= '0;
			showerr_q <= 1'b0;
			ext_q <= 1'b0;
			shown_q[0] <= 8'd1;
			shown_q[1] <= 8'd2;
			shown_q[2] <= 8'd3;
			shown_q[3] <= 8'd4;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					prsd_pkg::REG_TEMP_LIMIT: temp_lim_q <= cfg_data;
					prsd_pkg::REG_CURRENT_LIMIT: cur_lim_q <= cfg_data;
					prsd_pkg::REG_VOLT_HIGH: vhi_q <= cfg_data;
					prsd_pkg::REG_VOLT_LOW: vlo_q <= cfg_data;
					prsd_pkg::REG_FAULT_HOLD: fhold_q <= cfg_data[7:0];
					prsd_pkg::REG_EXT_HOLD: ehold_q <= cfg_data[7:0];
					prsd_pkg::REG_COOLDOWN: cool_ticks_q <= cfg_data[7:0];
					prsd_pkg::REG_STARTUP: grace_q <= cfg_data[4:0];
					default: ;
				endcase
			end
			case (state_q)
				S_IDLE: if (in_valid) begin
					ext_q <= ext_fault;
					if (grace_q != 5'd0) begin
						grace_q <= grace_q - 5'd1;
						for (int k = 0; k < 4; k++)
							shown_q[k] <= (grace_q - 5'd1 > 5'd10) ? prsd_pkg::SYM_DASH
								: 8'(k == 0 ? 19 : k == 1 ? 5 : k == 2 ? 14 : 23);
						state_q <= S_OUT;
					end else begin
						state_q <= S_MV;
					end
				end
				S_MV: state_q <= S_MI;
				S_MI: state_q <= S_MT;
				S_MT: state_q <= S_FH;
				S_FH: state_q <= S_CHK;
				S_CHK: begin
					hold_q <= h;
					code_q <= c;
					load_q <= ld;
					cool_q <= cl;
					if (showerr_q) begin
						for (int k = 0; k < 4; k++)
							shown_q[k] <= prsd_pkg::msg_digit(c, 2'(k));
						state_q <= S_DISP;
					end else if (mode_q == 3'd0) begin
						if (h != 8'd0) begin
							shown_q[0] <= prsd_pkg::SYM_E;
							shown_q[1] <= prsd_pkg::SYM_R;
							shown_q[2] <= prsd_pkg::SYM_R;
							shown_q[3] <= 8'(c);
						end else begin
							for (int k = 0; k < 4; k++)
								shown_q[k] <= prsd_pkg::msg_digit(prsd_pkg::FC_NONE, 2'(k));
						end
						state_q <= S_DISP;
					end else if (mode_q == 3'd7) begin
						state_q <= S_DISP;
					end else begin
						state_q <= S_BCD;
					end
				end
				S_BCD: if (stat.bcd_done) begin
					case (mode_q)
						3'd1: begin
							shown_q[0] <= 8'(d3[0]);
							shown_q[1] <= 8'(d3[1]) | prsd_pkg::DOT;
							shown_q[2] <= 8'(d3[2]);
							shown_q[3] <= 8'(d3[3]);
						end
						3'd5: begin
							shown_q[0] <= 8'(d3[1]);
							shown_q[1] <= 8'(d3[2]) | prsd_pkg::DOT;
							shown_q[2] <= 8'(d3[3]);
							shown_q[3] <= prsd_pkg::SYM_LC;
						end
						3'd6: begin
							shown_q[0] <= (d3[1] == 4'd0) ? prsd_pkg::SYM_BLANK : 8'(d3[1]);
							shown_q[1] <= 8'(d3[2]);
							shown_q[2] <= 8'(d3[3]);
							shown_q[3] <= prsd_pkg::SYM_F;
						end
						default: begin
							if (amps >= 14'd1000) begin
								shown_q[0] <= 8'(d3[0]);
								shown_q[1] <= 8'(d3[1]) | prsd_pkg::DOT;
								shown_q[2] <= 8'(d3[2]);
							end else begin
								shown_q[0] <= 8'(d3[1]) | prsd_pkg::DOT;
								shown_q[1] <= 8'(d3[2]);
								shown_q[2] <= 8'(d3[3]);
							end
							shown_q[3] <= prsd_pkg::SYM_A;
						end
					endcase
					state_q <= S_DISP;
				end
				S_DISP: begin
					dwell_q <= dwell_q + 3'd1;
					if (dwell_q == 3'd7) begin
						if (hold_q != 8'd0 && !showerr_q) begin
							showerr_q <= 1'b1;
						end else begin
							showerr_q <= 1'b0;
							mode_q <= (mode_q >= 3'd6) ? 3'd0 : mode_q + 3'd1;
						end
					end
					if (hold_q != 8'd0) begin
						hold_q <= hold_q - 8'd1;
						if (hold_q == 8'd1)
							code_q <= prsd_pkg::FC_NONE;
					end
					state_q <= S_OUT;
				end
				S_OUT: if (out_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`CHK_IMPL(a_code_range, clk, arst_n, 1'b1, code_q <= prsd_pkg::FC_TEMP)
	`CHK_IMPL(a_no_both, clk, arst_n, 1'b1, !(in_ready && out_valid))
	`CHK_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(code_q))
endmodule

@@ rtl/core/power_rail_supervisor_display_core.sv @@
// Top level of the power rail supervisor display
//  channel | signals                      | direction
//  request | in_valid in_ready in_data    | in
//  result  | out_valid out_ready out_data | out
//  config  | cfg_we cfg_idx cfg_data      | in
// In start-up grace a request goes from S_IDLE straight to S_OUT, then waits for out_ready.
// After grace it passes S_MV, S_MI, S_MT, S_FH, S_CHK, S_BCD if a value is shown, S_DISP
// and S_OUT; the 14-step decimal conversion, with load and finish, sets the longest path.
// Reset clears filters, counters and limits to their defaults asynchronously.
// A stalled result holds the block; no new request is taken until it leaves.
module power_rail_supervisor_display_core (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  prsd_pkg::in_t   in_data,
	output logic            out_valid,
	input  logic            out_ready,
	output prsd_pkg::out_t  out_data,
	input  logic            cfg_we,
	input  logic [2:0]      cfg_idx,
	input  logic [13:0]     cfg_data
);
	prsd_pkg::dp_cmd_t  cmd;
	prsd_pkg::dp_stat_t stat;
	logic [13:0] volts, amps;
	logic signed [12:0] deg;
	logic [9:0] fahr;
	logic [3:0] dig [4];
	logic [7:0] shown [4];
	logic load;
	logic [2:0] code;

	prsd_datapath u_dp (
		.clk, .arst_n, .req(in_data), .cmd, .stat,
		.volts, .amps, .deg, .fahr, .dig_q(dig)
	);

	prsd_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .ext_fault(in_data.ext_fault),
		.out_valid, .out_ready, .cfg_we, .cfg_idx, .cfg_data, .cmd, .stat,
		.volts, .amps, .deg, .dig, .shown_q(shown), .load_q(load), .code_q(code)
	);

	assign out_data = '{digit_0: shown[0], digit_1: shown[1], digit_2: shown[2],
		digit_3: shown[3], load_on: load, fault_code: code};
endmodule

@@ bench/tb_power_rail_supervisor_display_core.sv @@
// Testbench for the power rail supervisor display core: directed extreme and random ticks checked against a predictor
`timescale 1ns / 100ps
module tb_power_rail_supervisor_display_core;

	class supervisor_scoreboard;
		int unsigned temp_lim, cur_lim, vhi_lim, vlo_lim;
		int unsigned meas_hold, ext_hold, cool_ticks, start_ticks;
		int unsigned v_filt, i_filt, t_filt;
		int unsigned grace, cooldown, hold, mode, dwell;
		bit load, show_err;
		logic [2:0] code;
		logic [7:0] digits [4];
		prsd_pkg::out_t expected_q [$];
		int mismatches;

		function new();
			temp_lim = 450; cur_lim = 1500; vhi_lim = 1600; vlo_lim = 1000;
			meas_hold = 120; ext_hold = 40; cool_ticks = 60; start_ticks = 20;
			v_filt = 0; i_filt = 0; t_filt = 0;
			grace = 20; cooldown = 5; hold = 0; mode = 0; dwell = 0;
			load = 0; show_err = 0; code = prsd_pkg::FC_NONE;
			digits = '{8'd1, 8'd2, 8'd3, 8'd4};
			mismatches = 0;
		endfunction

		function void write_reg(logic [2:0] idx, logic [13:0] val);
			case (idx)
				prsd_pkg::REG_TEMP_LIMIT: temp_lim = 32'(val);
				prsd_pkg::REG_CURRENT_LIMIT: cur_lim = 32'(val);
				prsd_pkg::REG_VOLT_HIGH: vhi_lim = 32'(val);
				prsd_pkg::REG_VOLT_LOW: vlo_lim = 32'(val);
				prsd_pkg::REG_FAULT_HOLD: meas_hold = 32'(val[7:0]);
				prsd_pkg::REG_EXT_HOLD: ext_hold = 32'(val[7:0]);
				prsd_pkg::REG_COOLDOWN: cool_ticks = 32'(val[7:0]);
				prsd_pkg::REG_STARTUP: begin
					start_ticks = 32'(val[4:0]);
					grace = start_ticks;
				end
				default: ;
			endcase
		endfunction

		function int unsigned smooth(int unsigned prev, int unsigned smp);
			if (smp >= prev) return prev + (smp - prev) / 3;
			return prev - (prev - smp) / 3;
		endfunction

		function void raise(int unsigned h);
			if (hold < h) hold = h;
		endfunction

		function void cut();
			load = 0;
			cooldown = cool_ticks;
		endfunction

		function void set4(logic [7:0] a, logic [7:0] b, logic [7:0] c, logic [7:0] d);
			digits = '{a, b, c, d};
		endfunction

		function void message(logic [2:0] c);
			case (c)
				prsd_pkg::FC_NONE: set4(8'd9, 8'd20, 8'd20, 8'd13);
				prsd_pkg::FC_VHIGH: set4(8'd24, 8'd25, 8'd11, 8'd23);
				prsd_pkg::FC_VLOW: set4(8'd22, 8'd20, 8'd11, 8'd23);
				prsd_pkg::FC_IHIGH: set4(8'd24, 8'd25, 8'd12, 8'd19);
				prsd_pkg::FC_TEMP: set4(8'd24, 8'd20, 8'd23, 8'd21);
				default: set4(8'd11, 8'd10, 8'd13, 8'd21);
			endcase
		endfunction

		function void refresh(int unsigned volts, int unsigned amps, longint deg);
			int unsigned d;
			if (show_err) begin
				message(code);
				return;
			end
			case (mode)
				0: if (hold != 0)
						set4(prsd_pkg::SYM_E, prsd_pkg::SYM_R, prsd_pkg::SYM_R, 8'(code));
					else message(prsd_pkg::FC_NONE);
				1: set4(8'(volts / 1000), 8'((volts / 100) % 10) | prsd_pkg::DOT,
					8'((volts / 10) % 10), 8'(volts % 10));
				2, 3, 4: if (amps >= 1000)
						set4(8'(amps / 1000), 8'((amps / 100) % 10) | prsd_pkg::DOT,
							8'((amps / 10) % 10), prsd_pkg::SYM_A);
					else
						set4(8'(amps / 100) | prsd_pkg::DOT, 8'((amps / 10) % 10),
							8'(amps % 10), prsd_pkg::SYM_A);
				5, 6: begin
					d = deg < 0 ? 0 : 32'(deg);
					if (d > 999) d = 999;
					if (mode == 6) begin
						d = (d * 46 + 8192) >> 8;
						set4(d / 100 == 0 ? prsd_pkg::SYM_BLANK : 8'(d / 100),
							8'((d / 10) % 10), 8'(d % 10), prsd_pkg::SYM_F);
					end else
						set4(8'(d / 100), 8'((d / 10) % 10) | prsd_pkg::DOT, 8'(d % 10),
							prsd_pkg::SYM_LC);
				end
				default: ;
			endcase
		endfunction

		function void note_request(prsd_pkg::in_t r);
			int unsigned volts, amps;
			longint raw, deg;
			prsd_pkg::out_t e;
			v_filt = smooth(v_filt, 32'(r.volt_sample));
			i_filt = smooth(i_filt, 32'(r.current_sample));
			t_filt = smooth(t_filt, 32'(r.temp_sample));
			if (grace > 0) begin
				grace--;
				if (grace > 10)
					set4(prsd_pkg::SYM_DASH, prsd_pkg::SYM_DASH, prsd_pkg::SYM_DASH,
						prsd_pkg::SYM_DASH);
				else set4(prsd_pkg::SYM_R, 8'd5, prsd_pkg::SYM_E, prsd_pkg::SYM_T);
			end else begin
				volts = 32'((longint'(v_filt) * 2618) >> 16);
				if (volts > 9999) volts = 9999;
				amps = 32'((longint'(i_filt) * 2940) >> 16);
				if (amps > 9999) amps = 9999;
				raw = longint'(t_filt) * 3330 - longint'(600) * 65536;
				deg = raw >= 0 ? raw >>> 16 : -((-raw + 65535) >>> 16);
				if (cooldown > 0) begin
					cooldown--;
					if (cooldown == 0) load = 1;
				end
				if (r.ext_fault) begin raise(ext_hold); code = prsd_pkg::FC_EXT; cut(); end
				if (deg > longint'(temp_lim)) begin raise(meas_hold); code = prsd_pkg::FC_TEMP; end
				if (amps > cur_lim) begin raise(meas_hold); code = prsd_pkg::FC_IHIGH; cut(); end
				if (volts > vhi_lim) begin raise(meas_hold); code = prsd_pkg::FC_VHIGH; cut(); end
				if (volts < vlo_lim) begin raise(meas_hold); code = prsd_pkg::FC_VLOW; cut(); end
				refresh(volts, amps, deg);
				dwell = (dwell + 1) & 7;
				if (dwell == 0) begin
					if (hold != 0 && !show_err) show_err = 1;
					else begin
						show_err = 0;
						mode++;
						if (mode >= 7) mode = 0;
					end
				end
				if (hold > 0) begin
					hold--;
					if (hold == 0) code = prsd_pkg::FC_NONE;
				end
			end
			e.digit_0 = digits[0]; e.digit_1 = digits[1];
			e.digit_2 = digits[2]; e.digit_3 = digits[3];
			e.load_on = load; e.fault_code = code;
			expected_q.push_back(e);
		endfunction

		function void check_result(prsd_pkg::out_t got);
			prsd_pkg::out_t e;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %h", got);
				return;
			end
			e = expected_q.pop_front();
			if (got !== e) begin
				mismatches++;
				if (mismatches <= 10) $display("mismatch: expected %h actual %h", e, got);
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	prsd_pkg::in_t in_data = '0;
	logic out_valid;
	logic out_ready = 0;
	prsd_pkg::out_t out_data;
	logic cfg_we = 0;
	logic [2:0] cfg_idx = '0;
	logic [13:0] cfg_data = '0;
	supervisor_scoreboard sb = new();
	int idle_cycles = 0;

	always #10 clk = ~clk;

	power_rail_supervisor_display_core u_top (.*);

	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) sb.note_request(in_data);
		if (arst_n && out_valid && out_ready) sb.check_result(out_data);
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 2000) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin : receiver
		int gap;
		@(posedge arst_n);
		forever begin
			gap = $urandom_range(0, 10);
			if ($urandom_range(0, 3) == 0) gap = 0;
			if (gap != 0) begin
				out_ready <= 0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1;
			do @(posedge clk); while (!out_valid);
		end
	end

	task automatic write_reg(logic [2:0] idx, logic [13:0] val);
		cfg_we <= 1; cfg_idx <= idx; cfg_data <= val;
		@(posedge clk);
		sb.write_reg(idx, val);
		cfg_we <= 0;
		@(posedge clk);
	endtask

	task automatic send(prsd_pkg::in_t r, bit burst);
		int gap;
		gap = burst ? 0 : int'($urandom_range(0, 10));
		if (gap != 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1;
		in_data <= r;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic wait_empty();
		in_valid <= 0;
		@(posedge clk);
		while (sb.expected_q.size() != 0) @(posedge clk);
	endtask

	task automatic drain();
		wait_empty();
		repeat (20) @(posedge clk);
	endtask

	function automatic prsd_pkg::in_t rand_tick(int style);
		prsd_pkg::in_t r;
		r.volt_sample = 16'($urandom);
		r.current_sample = 16'($urandom);
		r.temp_sample = 16'($urandom);
		r.ext_fault = ($urandom_range(0, 15) == 0);
		if (style == 0) begin
			r.volt_sample = 16'($urandom_range(24000, 42000));
			r.current_sample = 16'($urandom_range(0, 36000));
			r.temp_sample = 16'($urandom_range(9000, 22000));
		end
		return r;
	endfunction

	initial begin : sender
		prsd_pkg::in_t r;
		int extremes [4] = '{0, 65535, 32768, 1};
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		write_reg(prsd_pkg::REG_STARTUP, 14'd11);
		for (int k = 0; k < 24; k++) begin
			r.volt_sample = 16'(extremes[k % 4]);
			r.current_sample = 16'(extremes[(k / 4) % 4]);
			r.temp_sample = 16'(extremes[(k + 1) % 4]);
			r.ext_fault = k[0];
			send(r, k < 12);
		end
		drain();
		for (int ph = 0; ph < 6; ph++) begin
			if (ph == 5) begin
				write_reg(prsd_pkg::REG_TEMP_LIMIT, 14'd450);
				write_reg(prsd_pkg::REG_CURRENT_LIMIT, 14'd1500);
				write_reg(prsd_pkg::REG_VOLT_HIGH, 14'd1600);
				write_reg(prsd_pkg::REG_VOLT_LOW, 14'd1000);
				write_reg(prsd_pkg::REG_FAULT_HOLD, 14'd1);
				write_reg(prsd_pkg::REG_EXT_HOLD, 14'd255);
				write_reg(prsd_pkg::REG_COOLDOWN, 14'd1);
				write_reg(prsd_pkg::REG_STARTUP, 14'd31);
			end else if (ph == 4) begin
				write_reg(prsd_pkg::REG_TEMP_LIMIT, 14'd9999);
				write_reg(prsd_pkg::REG_CURRENT_LIMIT, 14'd9999);
				write_reg(prsd_pkg::REG_VOLT_HIGH, 14'd9999);
				write_reg(prsd_pkg::REG_VOLT_LOW, 14'd0);
				write_reg(prsd_pkg::REG_FAULT_HOLD, 14'd255);
				write_reg(prsd_pkg::REG_EXT_HOLD, 14'd1);
				write_reg(prsd_pkg::REG_COOLDOWN, 14'd255);
				write_reg(prsd_pkg::REG_STARTUP, 14'd11);
			end else if (ph > 0) begin
				write_reg(prsd_pkg::REG_TEMP_LIMIT, 14'($urandom_range(0, 9999)));
				write_reg(prsd_pkg::REG_CURRENT_LIMIT, 14'($urandom_range(300, 1400)));
				write_reg(prsd_pkg::REG_VOLT_HIGH, 14'($urandom_range(1300, 2000)));
				write_reg(prsd_pkg::REG_VOLT_LOW, 14'($urandom_range(600, 1100)));
				write_reg(prsd_pkg::REG_FAULT_HOLD, 14'($urandom_range(1, 40)));
				write_reg(prsd_pkg::REG_EXT_HOLD, 14'($urandom_range(1, 40)));
				write_reg(prsd_pkg::REG_COOLDOWN, 14'($urandom_range(1, 30)));
				write_reg(prsd_pkg::REG_STARTUP, 14'($urandom_range(11, 31)));
			end
			for (int n = 0; n < 320; n++) begin
				send(rand_tick($urandom_range(0, 4) == 0), (n / 40) % 3 == 2);
				if (n == 160)
					wait_empty();
			end
			drain();
		end
		if (sb.mismatches == 0 && sb.expected_q.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule
